>>> sv/utf8sd_pkg.sv
package utf8sd_pkg;

  localparam int CpW = 21;
  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;

  // dfa state codes
  typedef enum logic [3:0] {
    StAccept = 4'd0,
    StReject = 4'd1,
    StNeed1  = 4'd2,
    StNeed2  = 4'd3,
    StE0     = 4'd4,
    StEd     = 4'd5,
    StF0     = 4'd6,
    StNeed3  = 4'd7,
    StF4     = 4'd8
  } dfa_state_e;

  // byte class codes
  typedef logic [3:0] byte_class_t;
  localparam byte_class_t ClsAscii   = 4'd0;
  localparam byte_class_t ClsCont80  = 4'd1;
  localparam byte_class_t ClsLead2   = 4'd2;
  localparam byte_class_t ClsLead3   = 4'd3;
  localparam byte_class_t ClsLeadEd  = 4'd4;
  localparam byte_class_t ClsLeadF4  = 4'd5;
  localparam byte_class_t ClsLead4   = 4'd6;
  localparam byte_class_t ClsContA0  = 4'd7;
  localparam byte_class_t ClsInvalid = 4'd8;
  localparam byte_class_t ClsCont90  = 4'd9;
  localparam byte_class_t ClsLeadE0  = 4'd10;
  localparam byte_class_t ClsLeadF0  = 4'd11;

  // run queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] codepoint;
    logic           is_replacement;
    logic           last_of_run;
    logic           string_done;
  } result_t;

  // all results caused by one byte
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } run_t;

  function automatic byte_class_t byte_class(input logic [7:0] b);
    byte_class_t c;
    if (b < 8'h80)       c = ClsAscii;
    else if (b < 8'h90)  c = ClsCont80;
    else if (b < 8'hA0)  c = ClsCont90;
    else if (b < 8'hC0)  c = ClsContA0;
    else if (b < 8'hC2)  c = ClsInvalid;
    else if (b < 8'hE0)  c = ClsLead2;
    else if (b == 8'hE0) c = ClsLeadE0;
    else if (b == 8'hED) c = ClsLeadEd;
    else if (b < 8'hF0)  c = ClsLead3;
    else if (b == 8'hF0) c = ClsLeadF0;
    else if (b < 8'hF4)  c = ClsLead4;
    else if (b == 8'hF4) c = ClsLeadF4;
    else                 c = ClsInvalid;
    return c;
  endfunction

  function automatic dfa_state_e next_state(input dfa_state_e st, input byte_class_t cls);
    dfa_state_e n;
    n = StReject;
    case (st)
      StAccept: begin
        case (cls)
          ClsAscii:  n = StAccept;
          ClsLead2:  n = StNeed1;
          ClsLead3:  n = StNeed2;
          ClsLeadEd: n = StEd;
          ClsLeadF4: n = StF4;
          ClsLead4:  n = StNeed3;
          ClsLeadE0: n = StE0;
          ClsLeadF0: n = StF0;
          default:   n = StReject;
        endcase
      end
      StNeed1: begin
        if (cls == ClsCont80 || cls == ClsContA0 || cls == ClsCont90) n = StAccept;
      end
      StNeed2: begin
        if (cls == ClsCont80 || cls == ClsContA0 || cls == ClsCont90) n = StNeed1;
      end
      StE0: begin
        if (cls == ClsContA0) n = StNeed1;
      end
      StEd: begin
        if (cls == ClsCont80 || cls == ClsCont90) n = StNeed1;
      end
      StF0: begin
        if (cls == ClsContA0 || cls == ClsCont90) n = StNeed2;
      end
      StNeed3: begin
        if (cls == ClsCont80 || cls == ClsContA0 || cls == ClsCont90) n = StNeed2;
      end
      StF4: begin
        if (cls == ClsCont80) n = StNeed2;
      end
      default: n = StReject;
    endcase
    return n;
  endfunction

endpackage

>>> sv/utf8sd_front.sv
module utf8sd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  utf8sd_pkg::in_item_t item_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output utf8sd_pkg::run_t    q_run_o
);
  import utf8sd_pkg::*;

  dfa_state_e     state_q, state_d;
  logic [CpW-1:0] partial_q, partial_d;

  logic           accept;
  byte_class_t    cls;
  dfa_state_e     ns1, ns2, st_mid;
  logic [CpW-1:0] p1, p2, part_mid;
  logic           fresh;
  logic           a_v, a_rep, x_v, x_rep;
  logic [CpW-1:0] a_cp, x_cp;
  logic           eos;

  assign accept = push && !q_full_i;
  assign eos    = item_i.end_of_string;
  assign cls    = byte_class(item_i.byte_in);
  assign ns1    = next_state(state_q, cls);
  assign ns2    = next_state(StAccept, cls);
  assign p1     = {partial_q[CpW-7:0], item_i.byte_in[5:0]};
  assign p2     = {{(CpW-8){1'b0}}, (8'hFF >> cls) & item_i.byte_in};

  always_comb begin
    a_v      = 1'b0;
    a_cp     = p1;
    a_rep    = 1'b0;
    fresh    = 1'b1;
    st_mid   = state_q;
    part_mid = partial_q;
    // continue an open sequence
    if (state_q != StAccept) begin
      fresh = 1'b0;
      if (ns1 == StAccept) begin
        a_v    = 1'b1;
        st_mid = StAccept;
      end else if (ns1 == StReject) begin
        a_v    = 1'b1;
        a_cp   = ReplChar;
        a_rep  = 1'b1;
        st_mid = StAccept;
        fresh  = 1'b1;
      end else begin
        st_mid   = ns1;
        part_mid = p1;
      end
    end
    // decode as a sequence start
    x_v   = 1'b0;
    x_cp  = p2;
    x_rep = 1'b0;
    if (fresh) begin
      if (ns2 == StAccept) begin
        x_v    = 1'b1;
        st_mid = StAccept;
      end else if (ns2 == StReject) begin
        x_v    = 1'b1;
        x_cp   = ReplChar;
        x_rep  = 1'b1;
        st_mid = StAccept;
      end else begin
        st_mid   = ns2;
        part_mid = p2;
      end
    end
    state_d   = st_mid;
    partial_d = part_mid;
    // truncated sequence at string end
    if (eos) begin
      if (st_mid != StAccept) begin
        x_v   = 1'b1;
        x_cp  = ReplChar;
        x_rep = 1'b1;
      end
      state_d   = StAccept;
      partial_d = '0;
    end else if (st_mid == StAccept) begin
      partial_d = '0;
    end
  end

  always_comb begin
    q_run_o.two                   = a_v && x_v;
    q_run_o.first.codepoint       = a_v ? a_cp : x_cp;
    q_run_o.first.is_replacement  = a_v ? a_rep : x_rep;
    q_run_o.first.last_of_run     = !(a_v && x_v);
    q_run_o.first.string_done     = eos && !(a_v && x_v);
    q_run_o.second.codepoint      = x_cp;
    q_run_o.second.is_replacement = x_rep;
    q_run_o.second.last_of_run    = 1'b1;
    q_run_o.second.string_done    = eos;
  end

  assign q_push_o = accept && (a_v || x_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StAccept;
      partial_q <= '0;
    end else if (accept) begin
      state_q   <= state_d;
      partial_q <= partial_d;
    end
  end

`ifndef SYNTHESIS
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && eos) |=> (state_q == StAccept && partial_q == '0))
    else $error("state not cleared after string end");
  a_no_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StReject)
    else $error("reject state held in register");
`endif

endmodule

>>> sv/utf8sd_queue.sv
module utf8sd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8sd_pkg::run_t run_i,
  output logic             full_o,
  output logic             valid_o,
  output utf8sd_pkg::run_t run_o,
  input  logic             pop_i
);
  import utf8sd_pkg::*;

  run_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign run_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("run pushed into full queue");
`endif

endmodule

>>> sv/utf8sd_back.sv
module utf8sd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  utf8sd_pkg::run_t    q_run_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output utf8sd_pkg::result_t result_o
);
  import utf8sd_pkg::*;

  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;
  logic    sel_q, sel_d;
  logic    load;

  assign load = q_valid_i && (!out_valid_q || pop);

  always_comb begin
    out_d       = out_q;
    sel_d       = sel_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_valid_q && !pop;
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = sel_q ? q_run_i.second : q_run_i.first;
      if (q_run_i.two && !sel_q) begin
        sel_d = 1'b1;
      end else begin
        sel_d   = 1'b0;
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  assign empty    = !out_valid_q;
  assign result_o = out_q;

`ifndef SYNTHESIS
  a_second_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (q_valid_i && q_run_i.two))
    else $error("second result pending without its run");
`endif

endmodule

>>> sv/utf8_stream_decoder.sv
// streaming utf-8 decoder, one byte of a string per input item
// input side is a queue sink: an item (byte plus end-of-string flag) is taken
//   at a clock edge where push is high and full is low
// result side is a queue source: while empty is low the oldest decoded
//   codepoint sits on result_o and is taken at an edge where pop is high
// each byte gives zero, one or two results; ill-formed input gives u+fffd,
//   last_of_run marks the final result of a byte, string_done the final
//   result of the string
// a result passes through the run queue and then the output register
// throughput: one byte per cycle while the run queue is not full; a byte that
//   gives two results holds the result register for both in turn, so a run of
//   such bytes is limited by the single output register draining the
//   two-entry run queue
// reset clears the dfa state, the partial codepoint, the run queue and the
//   output valid flag; the block is ready for a byte once reset is released
// when the receiver stalls, results wait in the output register and the run
//   queue; once the queue fills, full rises and input is held off
module utf8_stream_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  utf8sd_pkg::in_item_t item_i,
  output logic                 empty,
  input  logic                 pop,
  output utf8sd_pkg::result_t  result_o
);
  import utf8sd_pkg::*;

  // front to queue
  logic q_push;
  run_t q_run_in;
  logic q_full;

  // queue to back
  logic q_valid;
  run_t q_run_out;
  logic q_pop;

  // classify the byte, step the dfa and build the run of results
  utf8sd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_run_o  (q_run_in)
  );

  // short run queue decoupling decode from result delivery
  utf8sd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .run_i   (q_run_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .run_o   (q_run_out),
    .pop_i   (q_pop)
  );

  // hand out the results of each run one at a time
  utf8sd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_run_i   (q_run_out),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

  // input stalls only on a full run queue
  assign full = q_full;

endmodule
